[rtl/pend_pkg.sv]
// Shared types, constants and register map of the pendulum step engine.
package pend_pkg;

    // Field widths fixed by the register map and the result beat.
    localparam int DATA_W   = 32;
    localparam int DT_W     = 24;
    localparam int GAIN_W   = 24;
    localparam int APB_ADDR_W = 4;

    // Defaults for the sine table size and precision.
    localparam int SINE_ENTRIES_DEF = 1024;
    localparam int SINE_BITS_DEF    = 16;

    // Register values after reset.
    localparam logic              MODE_RESET        = 1'b0;
    localparam logic [DT_W-1:0]   STEP_TIME_RESET   = 24'd167772;
    localparam logic [GAIN_W-1:0] GAIN_RESET        = 24'd173842;
    localparam logic [DATA_W-1:0] START_ANGLE_RESET = 32'h2000_0000;

    // Sine table construction: pi/2 in Q30 and the Taylor series denominators
    // (2k)*(2k+1) for k = 1 to 12.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          TAYLOR_TERMS = 12;
    localparam logic [9:0]  TAYLOR_DEN [TAYLOR_TERMS] =
        '{10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
          10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600};

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_MODE_SELECT = 2'd0,
        REG_STEP_TIME   = 2'd1,
        REG_GAIN        = 2'd2,
        REG_START_ANGLE = 2'd3
    } cfg_idx_t;

    // Integration order.
    localparam logic MODE_EXPLICIT   = 1'b0;
    localparam logic MODE_SYMPLECTIC = 1'b1;

    typedef struct packed {
        logic              mode_select;
        logic [DT_W-1:0]   step_time;
        logic [GAIN_W-1:0] gain;
        logic [DATA_W-1:0] start_angle;
    } cfg_t;

    // Operand selection of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_ANG  = 3'd1,
        MUL_VEL  = 3'd2,
        MUL_POS  = 3'd3,
        MUL_INT  = 3'd4,
        MUL_GAIN = 3'd5
    } mul_sel_t;

    // Command word from the sequencer to the datapath.
    typedef struct packed {
        logic     load;
        logic     clr_sat;
        mul_sel_t mul;
        logic     rom_lo;
        logic     rom_hi;
        logic     mag;
        logic     upd_ang;
        logic     upd_vel;
        logic     upd_acc;
        logic     publish;
    } dp_cmd_t;

endpackage

[rtl/pend_regs.sv]
// Configuration register file behind the APB-style port.
module pend_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pend_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pend_pkg::DATA_W-1:0]        pwdata,
    output logic [pend_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    output pend_pkg::cfg_t                     cfg
);

    pend_pkg::cfg_t   cfg_reg;
    pend_pkg::cfg_t   cfg_next;
    pend_pkg::cfg_idx_t idx;
    logic             wr_en;

    assign idx    = pend_pkg::cfg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                pend_pkg::REG_MODE_SELECT: cfg_next.mode_select = pwdata[0];
                pend_pkg::REG_STEP_TIME:   cfg_next.step_time   = pwdata[pend_pkg::DT_W-1:0];
                pend_pkg::REG_GAIN:        cfg_next.gain        = pwdata[pend_pkg::GAIN_W-1:0];
                pend_pkg::REG_START_ANGLE: cfg_next.start_angle = pwdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pend_pkg::REG_MODE_SELECT: prdata = {31'b0, cfg_reg.mode_select};
            pend_pkg::REG_STEP_TIME:   prdata = {8'b0, cfg_reg.step_time};
            pend_pkg::REG_GAIN:        prdata = {8'b0, cfg_reg.gain};
            pend_pkg::REG_START_ANGLE: prdata = cfg_reg.start_angle;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_select <= pend_pkg::MODE_RESET;
            cfg_reg.step_time   <= pend_pkg::STEP_TIME_RESET;
            cfg_reg.gain        <= pend_pkg::GAIN_RESET;
            cfg_reg.start_angle <= pend_pkg::START_ANGLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/pend_ctrl.sv]
// Sequencer that walks one tick through the datapath and owns both handshakes.
module pend_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_valid,
    output logic              tick_ready,
    input  logic              restart,
    input  logic              mode_select,
    output logic              result_valid,
    input  logic              result_ready,
    output pend_pkg::dp_cmd_t cmd
);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'h0001,
        ST_E_ANG  = 14'h0002,
        ST_E_VEL  = 14'h0004,
        ST_ROM_LO = 14'h0008,
        ST_ROM_HI = 14'h0010,
        ST_INTERP = 14'h0020,
        ST_MAG    = 14'h0040,
        ST_GAIN   = 14'h0080,
        ST_ACC    = 14'h0100,
        ST_S_VMUL = 14'h0200,
        ST_S_VUPD = 14'h0400,
        ST_S_AMUL = 14'h0800,
        ST_S_AUPD = 14'h1000,
        ST_DONE   = 14'h2000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   mode_reg;
    logic   mode_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    assign tick_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        result_valid_next = result_valid_reg;
        cmd               = '0;
        cmd.mul           = pend_pkg::MUL_NONE;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    mode_next = mode_select;
                    if (restart)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (mode_select == pend_pkg::MODE_EXPLICIT)
                    begin
                        cmd.clr_sat = 1'b1;
                        cmd.mul     = pend_pkg::MUL_ANG;
                        state_next  = ST_E_ANG;
                    end
                    else
                    begin
                        cmd.clr_sat = 1'b1;
                        cmd.mul     = pend_pkg::MUL_POS;
                        state_next  = ST_ROM_LO;
                    end
                end
            end
            ST_E_ANG:
            begin
                cmd.upd_ang = 1'b1;
                cmd.mul     = pend_pkg::MUL_VEL;
                state_next  = ST_E_VEL;
            end
            ST_E_VEL:
            begin
                cmd.upd_vel = 1'b1;
                cmd.mul     = pend_pkg::MUL_POS;
                state_next  = ST_ROM_LO;
            end
            ST_ROM_LO:
            begin
                cmd.rom_lo = 1'b1;
                state_next = ST_ROM_HI;
            end
            ST_ROM_HI:
            begin
                cmd.rom_hi = 1'b1;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.mul    = pend_pkg::MUL_INT;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.mul    = pend_pkg::MUL_GAIN;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.upd_acc = 1'b1;
                state_next  = (mode_reg == pend_pkg::MODE_SYMPLECTIC) ? ST_S_VMUL : ST_DONE;
            end
            ST_S_VMUL:
            begin
                cmd.mul    = pend_pkg::MUL_VEL;
                state_next = ST_S_VUPD;
            end
            ST_S_VUPD:
            begin
                cmd.upd_vel = 1'b1;
                state_next  = ST_S_AMUL;
            end
            ST_S_AMUL:
            begin
                cmd.mul    = pend_pkg::MUL_ANG;
                state_next = ST_S_AUPD;
            end
            ST_S_AUPD:
            begin
                cmd.upd_ang = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.publish       = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mode_reg         <= pend_pkg::MODE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

[rtl/pend_dp.sv]
// Datapath: pendulum state, shared multiplier, sine table and result register.
module pend_dp #(
    parameter int SINE_ENTRIES = pend_pkg::SINE_ENTRIES_DEF,
    parameter int SINE_BITS    = pend_pkg::SINE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pend_pkg::cfg_t                    cfg,
    input  pend_pkg::dp_cmd_t                 cmd,
    output logic signed [pend_pkg::DATA_W-1:0] angle_out,
    output logic signed [pend_pkg::DATA_W-1:0] velocity_out,
    output logic signed [pend_pkg::DATA_W-1:0] accel_out,
    output logic                              saturated
);

    localparam int IDX_W  = $clog2(SINE_ENTRIES + 1);
    localparam int MAG_W  = SINE_BITS + 1;
    localparam int ACC_SH = SINE_BITS - 8;
    localparam int POS_W  = 30 + IDX_W;

    // Table entry i is sin(pi/2 * i / SINE_ENTRIES) in Q(SINE_BITS), from a
    // Q30 Taylor series that truncates each term, then rounded half up.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] q;
        longint      sum;
        x    = (64'(i) * pend_pkg::HALF_PI_Q30) / 64'(SINE_ENTRIES);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= pend_pkg::TAYLOR_TERMS; k++)
        begin
            term = ((term * x2) >> 30) / 64'(pend_pkg::TAYLOR_DEN[k-1]);
            if ((k % 2) == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        q = (64'(sum) + (64'd1 << (29 - SINE_BITS))) >> (30 - SINE_BITS);
        if (q > (64'd1 << SINE_BITS))
        begin
            q = 64'd1 << SINE_BITS;
        end
        return q[MAG_W-1:0];
    endfunction

    // Quarter-wave sine ROM with one registered read port.
    logic [MAG_W-1:0] sine_rom [SINE_ENTRIES+1];

    for (genvar g = 0; g <= SINE_ENTRIES; g++)
    begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    // Pendulum state.
    logic [31:0]        angle_reg;
    logic [31:0]        angle_next;
    logic signed [31:0] velocity_reg;
    logic signed [31:0] velocity_next;
    logic signed [31:0] accel_reg;
    logic signed [31:0] accel_next;
    logic               sat_reg;
    logic               sat_next;

    // Working registers.
    logic [63:0]        prod_reg;
    logic               prod_neg_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [29:0]        frac_reg;
    logic [MAG_W-1:0]   lo_reg;
    logic [MAG_W-1:0]   hi_reg;
    logic [MAG_W-1:0]   mag_reg;

    // Result register.
    logic [31:0]        angle_out_reg;
    logic [31:0]        velocity_out_reg;
    logic [31:0]        accel_out_reg;
    logic               sat_out_reg;

    logic [31:0]        v_mag;
    logic [31:0]        a_mag;
    logic [30:0]        p_mirror;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic               mul_neg;
    logic [63:0]        prod_next;

    logic [POS_W-1:0]   pos;
    logic [IDX_W-1:0]   idx_raw;
    logic [IDX_W-1:0]   idx_c;
    logic [29:0]        frac_c;
    logic [IDX_W-1:0]   rom_addr;
    logic [MAG_W-1:0]   diff;

    logic [31:0]        dang;
    logic signed [33:0] vsum;
    logic               vel_ovf;
    logic [31:0]        vel_sat;
    logic [63:0]        acc_mag;
    logic               acc_ovf;
    logic [31:0]        acc_sat;

    assign v_mag    = velocity_reg[31] ? (~velocity_reg + 32'd1) : velocity_reg;
    assign a_mag    = accel_reg[31] ? (~accel_reg + 32'd1) : accel_reg;
    assign p_mirror = angle_reg[30] ? (31'h4000_0000 - {1'b0, angle_reg[29:0]})
                                    : {1'b0, angle_reg[29:0]};
    assign diff     = hi_reg - lo_reg;

    always_comb
    begin
        unique case (cmd.mul)
            pend_pkg::MUL_ANG:
            begin
                mul_a   = v_mag;
                mul_b   = {8'b0, cfg.step_time};
                mul_neg = velocity_reg[31];
            end
            pend_pkg::MUL_VEL:
            begin
                mul_a   = a_mag;
                mul_b   = {8'b0, cfg.step_time};
                mul_neg = accel_reg[31];
            end
            pend_pkg::MUL_POS:
            begin
                mul_a   = {1'b0, p_mirror};
                mul_b   = 32'(SINE_ENTRIES);
                mul_neg = 1'b0;
            end
            pend_pkg::MUL_INT:
            begin
                mul_a   = {{(32-MAG_W){1'b0}}, diff};
                mul_b   = {2'b0, frac_reg};
                mul_neg = 1'b0;
            end
            pend_pkg::MUL_GAIN:
            begin
                // Acceleration opposes the sine: positive in the lower half turn.
                mul_a   = {{(32-MAG_W){1'b0}}, mag_reg};
                mul_b   = {8'b0, cfg.gain};
                mul_neg = ~angle_reg[31];
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
    end

    assign prod_next = {32'b0, mul_a} * {32'b0, mul_b};

    // Table position: integer part indexes, fraction interpolates.
    assign pos     = prod_reg[POS_W-1:0];
    assign idx_raw = pos[POS_W-1:30];

    always_comb
    begin
        if (idx_raw >= IDX_W'(SINE_ENTRIES))
        begin
            idx_c  = IDX_W'(SINE_ENTRIES);
            frac_c = '0;
        end
        else
        begin
            idx_c  = idx_raw;
            frac_c = pos[29:0];
        end
    end

    always_comb
    begin
        if (cmd.rom_hi)
        begin
            rom_addr = (idx_reg == IDX_W'(SINE_ENTRIES)) ? idx_reg : (idx_reg + 1'b1);
        end
        else
        begin
            rom_addr = idx_c;
        end
    end

    // Angle step, wrapping over a full turn.
    assign dang = prod_reg[47:16];

    // Velocity step with saturation.
    assign vsum = prod_neg_reg ? ({{2{velocity_reg[31]}}, velocity_reg} - {3'b0, prod_reg[54:24]})
                               : ({{2{velocity_reg[31]}}, velocity_reg} + {3'b0, prod_reg[54:24]});

    always_comb
    begin
        vel_ovf = (vsum[33:31] != 3'b000) && (vsum[33:31] != 3'b111);
        if (!vel_ovf)
        begin
            vel_sat = vsum[31:0];
        end
        else if (vsum[33])
        begin
            vel_sat = 32'h8000_0000;
        end
        else
        begin
            vel_sat = 32'h7FFF_FFFF;
        end
    end

    // Acceleration from the scaled product with saturation.
    assign acc_mag = prod_reg >> ACC_SH;

    always_comb
    begin
        if (prod_neg_reg)
        begin
            acc_ovf = (|acc_mag[63:32]) || (acc_mag[31] && (|acc_mag[30:0]));
            acc_sat = acc_ovf ? 32'h8000_0000 : (~acc_mag[31:0] + 32'd1);
        end
        else
        begin
            acc_ovf = |acc_mag[63:31];
            acc_sat = acc_ovf ? 32'h7FFF_FFFF : acc_mag[31:0];
        end
    end

    always_comb
    begin
        angle_next    = angle_reg;
        velocity_next = velocity_reg;
        accel_next    = accel_reg;
        sat_next      = sat_reg;
        if (cmd.load)
        begin
            angle_next    = cfg.start_angle;
            velocity_next = '0;
            accel_next    = '0;
            sat_next      = 1'b0;
        end
        if (cmd.clr_sat)
        begin
            sat_next = 1'b0;
        end
        if (cmd.upd_ang)
        begin
            angle_next = prod_neg_reg ? (angle_reg - dang) : (angle_reg + dang);
        end
        if (cmd.upd_vel)
        begin
            velocity_next = vel_sat;
            sat_next      = sat_next | vel_ovf;
        end
        if (cmd.upd_acc)
        begin
            accel_next = acc_sat;
            sat_next   = sat_next | acc_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg    <= pend_pkg::START_ANGLE_RESET;
            velocity_reg <= '0;
            accel_reg    <= '0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            angle_reg    <= angle_next;
            velocity_reg <= velocity_next;
            accel_reg    <= accel_next;
            sat_reg      <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul != pend_pkg::MUL_NONE)
        begin
            prod_reg     <= prod_next;
            prod_neg_reg <= mul_neg;
        end
        if (cmd.rom_lo)
        begin
            idx_reg  <= idx_c;
            frac_reg <= frac_c;
            lo_reg   <= sine_rom[rom_addr];
        end
        if (cmd.rom_hi)
        begin
            hi_reg <= sine_rom[rom_addr];
        end
        if (cmd.mag)
        begin
            mag_reg <= lo_reg + prod_reg[30+MAG_W-1:30];
        end
        if (cmd.publish)
        begin
            angle_out_reg    <= angle_reg;
            velocity_out_reg <= velocity_reg;
            accel_out_reg    <= accel_reg;
            sat_out_reg      <= sat_reg;
        end
    end

    assign angle_out    = angle_out_reg;
    assign velocity_out = velocity_out_reg;
    assign accel_out    = accel_out_reg;
    assign saturated    = sat_out_reg;

endmodule

[rtl/pendulum_euler_step.sv]
// Top level of the pendulum step engine: register file, sequencer and datapath.
//
// Each beat on the tick channel (tick_valid/tick_ready, field restart) either
// restarts the pendulum at start_angle with zero velocity and acceleration, or
// advances it by one step_time. Each tick yields exactly one beat on the result
// channel (result_valid/result_ready) carrying angle, velocity, acceleration and
// the saturation flag of that step.
// The block works on one tick at a time. A restart loads the start state and
// goes to the done state; explicit Euler order updates angle, then velocity,
// then reads the sine table and updates acceleration; symplectic order updates
// acceleration first, then velocity and angle. The steps come from the
// sequencer walking every product through one shared 32x32 multiplier and
// reading the two sine table neighbors through a single ROM port.
// A finished result sits in an output register, so the engine takes the next
// tick while the previous result beat is still waiting; if the receiver keeps
// result_ready low, the following tick finishes its work and then holds until
// the output register frees up.
// Reset loads the register defaults, puts the angle at the default start angle
// with zero motion, and leaves both channels empty. Registers are to be written
// by the user only while the engine is idle; the block does not enforce this.
module pendulum_euler_step #(
    parameter int SINE_ENTRIES = pend_pkg::SINE_ENTRIES_DEF,
    parameter int SINE_BITS    = pend_pkg::SINE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pend_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pend_pkg::DATA_W-1:0]        pwdata,
    output logic [pend_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               tick_valid,
    output logic                               tick_ready,
    input  logic                               restart,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [pend_pkg::DATA_W-1:0] angle_out,
    output logic signed [pend_pkg::DATA_W-1:0] velocity_out,
    output logic signed [pend_pkg::DATA_W-1:0] accel_out,
    output logic                               saturated
);

    // User holds register settings stable while a tick is in flight; unenforced.
    pend_pkg::cfg_t    cfg;
    // One command word per cycle from the sequencer into the datapath.
    pend_pkg::dp_cmd_t cmd;

    pend_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The sequencer picks the integration order when it accepts a tick and
    // raises result_valid once the datapath has published the new state.
    pend_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .restart      (restart),
        .mode_select  (cfg.mode_select),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    pend_dp #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .SINE_BITS    (SINE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .angle_out    (angle_out),
        .velocity_out (velocity_out),
        .accel_out    (accel_out),
        .saturated    (saturated)
    );

endmodule

[rtl/pend_checker.sv]
// Port-level checks on the pendulum step engine, bound to its top level.
module pend_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_valid,
    input  logic        tick_ready,
    input  logic        restart,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [31:0] angle_out,
    input  logic [31:0] velocity_out,
    input  logic [31:0] accel_out,
    input  logic        saturated
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(angle_out) &&
            $stable(velocity_out) && $stable(accel_out) && $stable(saturated))
    else $error("result beat changed while stalled");

    // The engine is busy in the cycle after it takes a tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
    else $error("tick taken while previous tick still in flight");

    // A restart on an empty output yields a zero-motion result via the done state.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready && restart && !result_valid |-> ##2
            (result_valid && velocity_out == 32'd0 && accel_out == 32'd0 && !saturated))
    else $error("restart result missing or not at rest");

endmodule

bind pendulum_euler_step pend_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .restart      (restart),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .angle_out    (angle_out),
    .velocity_out (velocity_out),
    .accel_out    (accel_out),
    .saturated    (saturated)
);

[dv/pendulum_step_checker.sv]
// Checker for the pendulum step engine: predicts each result beat and compares it.
module pendulum_step_checker
    import pend_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]         pwdata,
    input  logic                      tick_valid,
    input  logic                      tick_ready,
    input  logic                      restart,
    input  logic                      result_valid,
    input  logic                      result_ready,
    input  logic signed [DATA_W-1:0]  angle_out,
    input  logic signed [DATA_W-1:0]  velocity_out,
    input  logic signed [DATA_W-1:0]  accel_out,
    input  logic                      saturated,
    output int                        pending,
    output int                        mismatches
);

    localparam int TAB_N     = SINE_ENTRIES_DEF;
    localparam int TAB_BITS  = SINE_BITS_DEF;
    localparam int ACC_SHIFT = TAB_BITS - 8;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [DATA_W-1:0]        angle;
        logic signed [DATA_W-1:0] velocity;
        logic signed [DATA_W-1:0] accel;
        logic                     sat;
    } pend_state_t;

    cfg_t                     cfg;
    logic [DATA_W-1:0]        angle_now;
    logic signed [DATA_W-1:0] vel_now;
    logic signed [DATA_W-1:0] acc_now;
    logic [31:0]              sine_tab [0:TAB_N];
    pend_state_t              expected_states [$];
    int                       mismatch_count = 0;

    assign mismatches = mismatch_count;

    // Quarter-wave sine table: Taylor series in Q30, truncating per term, then
    // rounded half up to TAB_BITS fraction bits.
    initial begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint          sum;
        for (int i = 0; i <= TAB_N; i++) begin
            x    = (64'(i) * HALF_PI_Q30) / 64'(TAB_N);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
            if (sum < 0)
                sum = 0;
            q = (64'(sum) + (64'd1 << (29 - TAB_BITS))) >> (30 - TAB_BITS);
            if (q > (64'd1 << TAB_BITS))
                q = 64'd1 << TAB_BITS;
            sine_tab[i] = q[31:0];
        end
    end

    // a * b / 2^sh with the magnitude truncated, so the result rounds toward zero.
    function automatic longint scaled_product(longint a, longint unsigned b, int sh);
        longint unsigned m;
        m = (a < 0) ? -a : a;
        m = (m * b) >> sh;
        return (a < 0) ? -signed'(m) : signed'(m);
    endfunction

    function automatic logic signed [DATA_W-1:0] clip32(longint v, inout bit hit);
        if (v > S32_MAX) begin
            hit = 1'b1;
            return S32_MAX[DATA_W-1:0];
        end
        if (v < S32_MIN) begin
            hit = 1'b1;
            return S32_MIN[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    // Signed sine of a turn fraction, interpolated between table neighbors.
    function automatic longint sine_value(logic [DATA_W-1:0] ang);
        longint unsigned p;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        p = ang[29:0];
        if (ang[30])
            p = 64'd1073741824 - p;
        pos  = p * TAB_N;
        idx  = pos >> 30;
        frac = pos & 64'h3FFF_FFFF;
        if (idx >= TAB_N) begin
            idx  = TAB_N;
            frac = 0;
        end
        lo  = sine_tab[idx];
        hi  = (idx < TAB_N) ? sine_tab[idx + 1] : lo;
        mag = lo + (((hi - lo) * frac) >> 30);
        return ang[31] ? -signed'(mag) : signed'(mag);
    endfunction

    function automatic logic signed [DATA_W-1:0] accel_at(logic [DATA_W-1:0] ang,
                                                          inout bit hit);
        return clip32(-scaled_product(sine_value(ang), cfg.gain, ACC_SHIFT), hit);
    endfunction

    // Moves the predicted pendulum by one tick and returns the state to be seen.
    function automatic pend_state_t advance_pendulum(logic restart_now);
        pend_state_t r;
        bit          hit;
        hit = 1'b0;
        if (restart_now) begin
            angle_now = cfg.start_angle;
            vel_now   = '0;
            acc_now   = '0;
        end else if (cfg.mode_select == MODE_EXPLICIT) begin
            angle_now = angle_now + 32'(scaled_product(vel_now, cfg.step_time, 16));
            vel_now   = clip32(longint'(vel_now)
                               + scaled_product(acc_now, cfg.step_time, 24), hit);
            acc_now   = accel_at(angle_now, hit);
        end else begin
            acc_now   = accel_at(angle_now, hit);
            vel_now   = clip32(longint'(vel_now)
                               + scaled_product(acc_now, cfg.step_time, 24), hit);
            angle_now = angle_now + 32'(scaled_product(vel_now, cfg.step_time, 16));
        end
        r.angle    = angle_now;
        r.velocity = vel_now;
        r.accel    = acc_now;
        r.sat      = hit;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        pend_state_t want;
        if (!rst_n) begin
            cfg.mode_select = MODE_RESET;
            cfg.step_time   = STEP_TIME_RESET;
            cfg.gain        = GAIN_RESET;
            cfg.start_angle = START_ANGLE_RESET;
            angle_now       = START_ANGLE_RESET;
            vel_now         = '0;
            acc_now         = '0;
            expected_states.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (cfg_idx_t'(paddr[3:2]))
                    REG_MODE_SELECT: cfg.mode_select = pwdata[0];
                    REG_STEP_TIME:   cfg.step_time   = pwdata[DT_W-1:0];
                    REG_GAIN:        cfg.gain        = pwdata[GAIN_W-1:0];
                    REG_START_ANGLE: cfg.start_angle = pwdata;
                endcase
            end
            // Results are matched before the new tick is queued, so an early
            // result beat can never pair with the tick taken on the same edge.
            if (result_valid && result_ready) begin
                if (expected_states.size() == 0) begin
                    note_mismatch($sformatf("result beat with no tick outstanding, angle %h",
                                            angle_out));
                end else begin
                    want = expected_states.pop_front();
                    if (angle_out !== want.angle)
                        note_mismatch($sformatf("angle_out %h, expected %h",
                                                angle_out, want.angle));
                    if (velocity_out !== want.velocity)
                        note_mismatch($sformatf("velocity_out %h, expected %h",
                                                velocity_out, want.velocity));
                    if (accel_out !== want.accel)
                        note_mismatch($sformatf("accel_out %h, expected %h",
                                                accel_out, want.accel));
                    if (saturated !== want.sat)
                        note_mismatch($sformatf("saturated %b, expected %b",
                                                saturated, want.sat));
                end
            end
            if (tick_valid && tick_ready)
                expected_states.push_back(advance_pendulum(restart));
            pending <= expected_states.size();
        end
    end

endmodule

[dv/pendulum_euler_step_tb.sv]
// Testbench top for the pendulum step engine: stimulus, flow control and verdict.
module pendulum_euler_step_tb;
    import pend_pkg::*;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr        = '0;
    logic [DATA_W-1:0]         pwdata       = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      tick_valid   = 1'b0;
    logic                      tick_ready;
    logic                      restart      = 1'b0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    logic signed [DATA_W-1:0]  angle_out;
    logic signed [DATA_W-1:0]  velocity_out;
    logic signed [DATA_W-1:0]  accel_out;
    logic                      saturated;

    // Flow control knobs: percent chance that the sender inserts a gap before a
    // tick, and percent of cycles in which the receiver drops result_ready.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    // Set while a long receiver hold-off is running.
    logic rx_hold        = 1'b0;

    int   pending;
    int   mismatches;

    always #5 clk = ~clk;

    pendulum_euler_step i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .restart      (restart),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .angle_out    (angle_out),
        .velocity_out (velocity_out),
        .accel_out    (accel_out),
        .saturated    (saturated)
    );

    // The checker watches the configuration port and both channels on its own;
    // it reports how many ticks still wait for their result beat and how many
    // mismatches it has seen.
    pendulum_step_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .restart      (restart),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .angle_out    (angle_out),
        .velocity_out (velocity_out),
        .accel_out    (accel_out),
        .saturated    (saturated),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    // Receiver: a fresh ready decision every cycle, forced low during a hold-off.
    always @(posedge clk)
    begin
        result_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Keeps result_ready low for a long stretch so that the engine fills its
    // output register, finishes the next tick and then refuses further ticks.
    task automatic hold_results(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    // One APB write: setup cycle, then access cycle; the register takes the
    // value on the edge where penable and pready are both high.
    task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops offering ticks and waits until every accepted tick has delivered its
    // result beat. The first edge lets a tick taken on the current edge show up
    // in the checker's count before it is looked at.
    task automatic drain_results();
        tick_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Registers change only with the engine idle. Every call writes all four,
    // with whatever upper bits the caller puts in the words.
    task automatic program_pendulum(input logic [DATA_W-1:0] mode_word,
                                    input logic [DATA_W-1:0] step_word,
                                    input logic [DATA_W-1:0] gain_word,
                                    input logic [DATA_W-1:0] start_word);
        drain_results();
        write_reg(REG_MODE_SELECT, mode_word);
        write_reg(REG_STEP_TIME, step_word);
        write_reg(REG_GAIN, gain_word);
        write_reg(REG_START_ANGLE, start_word);
    endtask

    // Offers one tick beat and returns on the edge that accepts it. tick_valid is
    // only lowered when a gap is taken, so back-to-back beats keep it high.
    task automatic offer_tick(input logic restart_now);
        if ($urandom_range(99) < send_idle_pct) begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clk);
        end
        tick_valid <= 1'b1;
        restart    <= restart_now;
        do @(posedge clk); while (!tick_ready);
    endtask

    initial
    begin
        int              phase;
        int              beat;
        logic [DT_W-1:0]   step_pick;
        logic [GAIN_W-1:0] gain_pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The first beat is a plain step, so it checks the state
        // left by reset rather than one loaded by a restart.
        program_pendulum(MODE_EXPLICIT, STEP_TIME_RESET, GAIN_RESET, START_ANGLE_RESET);
        offer_tick(1'b0);
        offer_tick(1'b0);
        offer_tick(1'b1);
        offer_tick(1'b0);

        // Symplectic order. The new start angle must not disturb the running
        // state; it only shows after the restart.
        program_pendulum(MODE_SYMPLECTIC, STEP_TIME_RESET, GAIN_RESET, 32'h1234_5678);
        offer_tick(1'b0);
        offer_tick(1'b0);
        offer_tick(1'b1);
        offer_tick(1'b0);

        // Largest step and gain from a quarter turn: the sine lookup hits the
        // last table entry, acceleration clips at once and velocity soon after.
        program_pendulum(MODE_EXPLICIT, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h4000_0000);
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b0);
        offer_tick(1'b0);

        // Same extremes in symplectic order from half a turn, the most negative angle.
        program_pendulum(MODE_SYMPLECTIC, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h8000_0000);
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b0);

        // Zero step and zero gain: nothing may move, from the most positive angle.
        program_pendulum(MODE_EXPLICIT, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        offer_tick(1'b1);
        offer_tick(1'b0);

        // Smallest gain from three quarters of a turn with the largest step.
        program_pendulum(MODE_SYMPLECTIC, 32'h00FF_FFFF, 32'h0000_0001, 32'hC000_0000);
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b0);

        // Mode word with every upper bit set: only bit 0 counts, so this is
        // explicit order. Upper bits on step and gain must be dropped as well.
        program_pendulum(32'hFFFF_FFFE, 32'hFF00_0100, 32'hFF00_4000, 32'h0000_0000);
        offer_tick(1'b1);
        offer_tick(1'b0);

        // Random part: eight phases, alternating integration order, walking the
        // flow control patterns, with extreme settings in some phases.
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            case (phase)
                3: begin
                    step_pick = '1;
                    gain_pick = '1;
                end
                5: begin
                    step_pick = 24'($urandom);
                    gain_pick = 24'($urandom);
                end
                6: begin
                    step_pick = '0;
                    gain_pick = 24'($urandom);
                end
                default: begin
                    // Realistic pendulums, so that long runs swing instead of clipping.
                    step_pick = $urandom_range(400000, 1000);
                    gain_pick = $urandom_range(400000, 20000);
                end
            endcase
            program_pendulum({31'($urandom), 1'(phase % 2)}, {8'($urandom), step_pick},
                             {8'($urandom), gain_pick}, $urandom);
            // In the first stalling phase the receiver holds off for a long
            // stretch while the sender keeps offering ticks back to back.
            if (phase == 2) begin
                fork
                    hold_results(200);
                join_none
            end
            for (beat = 0; beat < 106; beat++)
                offer_tick($urandom_range(11) == 0);
        end

        drain_results();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule

[pendulum_euler_step.f]
rtl/pend_pkg.sv
rtl/pend_regs.sv
rtl/pend_ctrl.sv
rtl/pend_dp.sv
rtl/pendulum_euler_step.sv
rtl/pend_checker.sv
dv/pendulum_step_checker.sv
dv/pendulum_euler_step_tb.sv
